/* hw/rtl/crc16fpr_pkg.sv */
// shared types, constants and the crc byte update for the framed packet receiver
`default_nettype none

package crc16fpr_pkg;

  // frame delimiters and crc constants
  localparam logic [7:0]  StartByte      = 8'hAA;
  localparam logic [7:0]  OpcodeNone     = 8'hFF;
  localparam logic [15:0] CrcPoly        = 16'h1021;
  localparam logic [15:0] MaxLengthReset = 16'd5108;

  // parser phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_OPCODE = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_DATA   = 3'd4,
    PH_CRC_LO = 3'd5,
    PH_CRC_HI = 3'd6
  } phase_e;

  // events reported with each result
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_START  = 3'd1,
    EV_DATA   = 3'd2,
    EV_GOOD   = 3'd3,
    EV_CRCERR = 3'd4,
    EV_LENERR = 3'd5
  } event_e;

  // crc-16 (0x1021, msb first) advanced by one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/crc16_framed_packet_receiver_top.sv */
// Framed packet receiver: takes one byte per request and parses frames of the form
// 0xAA, opcode, 16-bit little-endian length, payload and 16-bit little-endian crc
// (crc-16 poly 0x1021, seed 0, over start byte, opcode, length and payload). Every
// accepted byte gives exactly one result: a header/discard marker, start seen, a
// payload byte with its offset, frame good, crc error or length error (length above
// the configured maximum). The block takes one byte every cycle while results are
// taken; a result shows on the output in the cycle after its byte is accepted and is
// held in an output register until taken. While a result waits untaken the input is
// held off, except in a cycle where out_ready_i takes the waiting result. The
// maximum length register is written through the cfg channel.
`default_nettype none

module crc16_framed_packet_receiver_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       event_res_o,
  output logic [7:0]       payload_byte_o,
  output logic [15:0]      payload_offset_o,
  output logic [7:0]       frame_opcode_o,
  output logic [15:0]      frame_length_o
);

  // parser state
  crc16fpr_pkg::phase_e phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [15:0] length_q, length_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] max_len_q;

  // result register
  logic                 out_valid_q;
  crc16fpr_pkg::event_e ev_q, ev_d;
  logic [7:0]           pbyte_q, pbyte_d;
  logic [15:0]          poff_q, poff_d;
  logic [7:0]           rop_q, rop_d;
  logic [15:0]          rlen_q, rlen_d;

  logic        in_fire;
  logic [15:0] crc_next;
  logic [15:0] len_full;
  logic [15:0] pos_inc;
  logic        end_frame;

  // handshakes
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign crc_next = crc16fpr_pkg::crc_feed(crc_q, rx_byte_i);
  assign len_full = {rx_byte_i, length_q[7:0]};
  assign pos_inc  = pos_q + 16'd1;

  // next state and result for one byte
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    opcode_d  = opcode_q;
    length_d  = length_q;
    crc_d     = crc_q;
    crc_lo_d  = crc_lo_q;
    ev_d      = crc16fpr_pkg::EV_NONE;
    pbyte_d   = 8'h00;
    poff_d    = 16'h0000;
    end_frame = 1'b0;
    case (phase_q)
      crc16fpr_pkg::PH_OPCODE: begin
        opcode_d = rx_byte_i;
        crc_d    = crc_next;
        phase_d  = crc16fpr_pkg::PH_LEN_LO;
      end
      crc16fpr_pkg::PH_LEN_LO: begin
        length_d = {8'h00, rx_byte_i};
        crc_d    = crc_next;
        phase_d  = crc16fpr_pkg::PH_LEN_HI;
      end
      crc16fpr_pkg::PH_LEN_HI: begin
        length_d = len_full;
        crc_d    = crc_next;
        pos_d    = 16'h0000;
        if (len_full > max_len_q) begin
          ev_d      = crc16fpr_pkg::EV_LENERR;
          end_frame = 1'b1;
        end else if (len_full == 16'h0000) begin
          phase_d = crc16fpr_pkg::PH_CRC_LO;
        end else begin
          phase_d = crc16fpr_pkg::PH_DATA;
        end
      end
      crc16fpr_pkg::PH_DATA: begin
        ev_d    = crc16fpr_pkg::EV_DATA;
        pbyte_d = rx_byte_i;
        poff_d  = pos_q;
        crc_d   = crc_next;
        pos_d   = pos_inc;
        if (pos_inc >= length_q) begin
          phase_d = crc16fpr_pkg::PH_CRC_LO;
        end
      end
      crc16fpr_pkg::PH_CRC_LO: begin
        crc_lo_d = rx_byte_i;
        phase_d  = crc16fpr_pkg::PH_CRC_HI;
      end
      crc16fpr_pkg::PH_CRC_HI: begin
        ev_d      = ({rx_byte_i, crc_lo_q} == crc_q) ? crc16fpr_pkg::EV_GOOD
                                                     : crc16fpr_pkg::EV_CRCERR;
        end_frame = 1'b1;
      end
      default: begin
        // idle, also any unused phase code: clear, then look for the start byte
        phase_d  = crc16fpr_pkg::PH_IDLE;
        pos_d    = 16'h0000;
        opcode_d = crc16fpr_pkg::OpcodeNone;
        length_d = 16'h0000;
        crc_d    = 16'h0000;
        crc_lo_d = 8'h00;
        if (rx_byte_i == crc16fpr_pkg::StartByte) begin
          ev_d    = crc16fpr_pkg::EV_START;
          crc_d   = crc16fpr_pkg::crc_feed(16'h0000, rx_byte_i);
          phase_d = crc16fpr_pkg::PH_OPCODE;
        end
      end
    endcase
    // report the frame header before any end-of-frame clear
    rop_d  = opcode_d;
    rlen_d = length_d;
    if (end_frame) begin
      phase_d  = crc16fpr_pkg::PH_IDLE;
      pos_d    = 16'h0000;
      opcode_d = crc16fpr_pkg::OpcodeNone;
      length_d = 16'h0000;
      crc_d    = 16'h0000;
      crc_lo_d = 8'h00;
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= crc16fpr_pkg::PH_IDLE;
      pos_q    <= 16'h0000;
      opcode_q <= crc16fpr_pkg::OpcodeNone;
      length_q <= 16'h0000;
      crc_q    <= 16'h0000;
      crc_lo_q <= 8'h00;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      opcode_q <= opcode_d;
      length_q <= length_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  // maximum length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= crc16fpr_pkg::MaxLengthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_q    <= ev_d;
      pbyte_q <= pbyte_d;
      poff_q  <= poff_d;
      rop_q   <= rop_d;
      rlen_q  <= rlen_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_res_o      = ev_q;
  assign payload_byte_o   = pbyte_q;
  assign payload_offset_o = poff_q;
  assign frame_opcode_o   = rop_q;
  assign frame_length_o   = rlen_q;

  // a payload phase always has a nonzero length to count against
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == crc16fpr_pkg::PH_DATA) |-> (length_q != 16'h0000))
    else $error("payload phase with zero length");

  // payload offsets stay inside the frame length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ev_q == crc16fpr_pkg::EV_DATA) |-> (poff_q < rlen_q))
    else $error("payload offset beyond frame length");

  // the second crc byte always ends the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == crc16fpr_pkg::PH_CRC_HI) |=> (phase_q == crc16fpr_pkg::PH_IDLE))
    else $error("frame not closed after crc");

  // a start event reports a cleared header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ev_q == crc16fpr_pkg::EV_START)
      |-> (rop_q == crc16fpr_pkg::OpcodeNone && rlen_q == 16'h0000))
    else $error("stale header on start event");

endmodule

`default_nettype wire
